// ----- rtl/core/wpm_pkg.sv -----
// shared types and constants for the wildcard pattern matcher
package wpm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int POS_W       = $clog2(MAX_PATTERN + 1);
	localparam int PAT_REGS    = 4;
	localparam int CFG_W       = 64;
	localparam int ADDR_W      = 6;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_ANY  = 8'h3F;
	localparam logic [7:0] CH_DOT  = 8'h2E;

	localparam logic [2:0] REG_PAT0   = 3'd0;
	localparam logic [2:0] REG_PAT1   = 3'd1;
	localparam logic [2:0] REG_PAT2   = 3'd2;
	localparam logic [2:0] REG_PAT3   = 3'd3;
	localparam logic [2:0] REG_LENGTH = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       char_valid;
		logic       last;
	} text_item_t;

	typedef struct packed {
		logic matched;
		logic final_res;
	} result_item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       char_valid;
		logic       last;
		logic       take;
		logic       settle;
	} cell_ctl_t;

endpackage

// ----- rtl/core/wpm_regs.sv -----
// configuration registers with apb access
module wpm_regs (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [wpm_pkg::ADDR_W-1:0]               paddr,
	input  logic [wpm_pkg::CFG_W-1:0]                pwdata,
	output logic [wpm_pkg::CFG_W-1:0]                prdata,
	output logic                                     pready,
	output logic [wpm_pkg::MAX_PATTERN-1:0][7:0]     pat_bytes,
	output logic [wpm_pkg::POS_W-1:0]                pat_len
);

	logic [wpm_pkg::PAT_REGS-1:0][wpm_pkg::CFG_W-1:0] pat_q;
	logic [5:0]                                       len_q;
	logic [2:0]                                       idx;
	logic                                             wr;

	assign idx    = paddr[5:3];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
		end else if (wr) begin
			unique case (idx)
				wpm_pkg::REG_PAT0:   pat_q[0] <= pwdata;
				wpm_pkg::REG_PAT1:   pat_q[1] <= pwdata;
				wpm_pkg::REG_PAT2:   pat_q[2] <= pwdata;
				wpm_pkg::REG_PAT3:   pat_q[3] <= pwdata;
				wpm_pkg::REG_LENGTH: len_q    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wpm_pkg::REG_PAT0:   prdata = pat_q[0];
			wpm_pkg::REG_PAT1:   prdata = pat_q[1];
			wpm_pkg::REG_PAT2:   prdata = pat_q[2];
			wpm_pkg::REG_PAT3:   prdata = pat_q[3];
			wpm_pkg::REG_LENGTH: prdata = {{(wpm_pkg::CFG_W-6){1'b0}}, len_q};
			default:             prdata = '0;
		endcase
	end

	assign pat_bytes = pat_q;

	// lengths above the pattern size saturate
	assign pat_len = (len_q > 6'(wpm_pkg::MAX_PATTERN)) ?
		wpm_pkg::POS_W'(wpm_pkg::MAX_PATTERN) : wpm_pkg::POS_W'(len_q);

endmodule

// ----- rtl/core/wpm_cell.sv -----
// one pattern position: active bit, star closure and advance to the next cell
module wpm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  wpm_pkg::cell_ctl_t ctl,
	input  logic [7:0]         pat_byte,
	input  logic               in_use,
	input  logic               present,
	input  logic               seed,
	input  logic               close_in,
	input  logic               adv_in,
	input  logic               close2_in,
	output logic               close_out,
	output logic               adv_out,
	output logic               close2_out,
	output logic               closed2
);

	logic state_q;
	logic nxt_s1;
	logic is_star;
	logic hit;
	logic closed;
	logic nxt;

	assign is_star = (pat_byte == wpm_pkg::CH_STAR);
	assign hit     = (pat_byte == ctl.text_byte) ||
		((pat_byte == wpm_pkg::CH_ANY) && (ctl.text_byte != wpm_pkg::CH_DOT));

	// closure of the stored set with the current pattern
	assign closed    = present & (state_q | seed | close_in);
	assign close_out = closed & in_use & is_star;
	assign adv_out   = closed & in_use & ~is_star & hit;
	assign nxt       = ctl.char_valid ? (close_out | adv_in) : closed;

	// closure of the advanced set for the verdict
	assign closed2    = present & (nxt_s1 | close2_in);
	assign close2_out = closed2 & in_use & is_star;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 1'b0;
		end else if (ctl.take) begin
			state_q <= nxt & ~ctl.last;
		end else if (ctl.settle) begin
			// close the advanced set while the pattern of its transaction is still loaded
			state_q <= closed;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			nxt_s1 <= nxt;
		end
	end

endmodule

// ----- rtl/core/wildcard_pattern_matcher.sv -----
// top level: wildcard pattern matcher over a row of position cells
//
// channel | direction | handshake                  | payload
// text    | in        | text_valid / text_ready    | text_item (text_item_t)
// result  | out       | result_valid / result_ready | result_item (result_item_t)
// config  | in        | psel, penable, pready      | paddr, pwdata, prdata
//
// one text transaction per cycle unless stalled; results pass stage 1, then the output register
// stage 1 ripples closure and advance through the 33 cells, the output stage closes again
// reset restarts the active set at position zero and clears the pattern
// a stalled result holds the output register, then stage 1; text_ready drops when both are full
module wildcard_pattern_matcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            text_valid,
	output logic                            text_ready,
	input  wpm_pkg::text_item_t             text_item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output wpm_pkg::result_item_t           result_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wpm_pkg::ADDR_W-1:0]      paddr,
	input  logic [wpm_pkg::CFG_W-1:0]       pwdata,
	output logic [wpm_pkg::CFG_W-1:0]       prdata,
	output logic                            pready
);

	localparam int NP = wpm_pkg::MAX_PATTERN;

	logic [NP-1:0][7:0]           pat_bytes;
	logic [wpm_pkg::POS_W-1:0]    pat_len;
	wpm_pkg::cell_ctl_t           ctl;
	logic                         take;
	logic                         adv;
	logic                         s1_vld_q;
	logic                         last_s1;
	logic                         fresh_q;
	logic                         res_vld_q;
	wpm_pkg::result_item_t        res_q;
	logic [NP+1:0]                close_c;
	logic [NP+1:0]                adv_c;
	logic [NP+1:0]                close2_c;
	logic [NP:0]                  closed2;

	wpm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pat_bytes (pat_bytes),
		.pat_len   (pat_len)
	);

	assign adv        = ~res_vld_q | result_ready;
	assign text_ready = ~s1_vld_q | adv;
	assign take       = text_valid & text_ready;

	assign ctl.text_byte  = text_item.text_byte;
	assign ctl.char_valid = text_item.char_valid;
	assign ctl.last       = text_item.last;
	assign ctl.take       = take;
	assign ctl.settle     = s1_vld_q & ~last_s1;

	assign close_c[0]  = 1'b0;
	assign adv_c[0]    = 1'b0;
	assign close2_c[0] = 1'b0;

	for (genvar p = 0; p <= NP; p++) begin : g_cell
		logic [7:0] pb;
		if (p < NP) begin : g_byte
			assign pb = pat_bytes[p];
		end else begin : g_tail
			assign pb = 8'h00;
		end
		wpm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.pat_byte   (pb),
			.in_use     (pat_len > wpm_pkg::POS_W'(p)),
			.present    (pat_len >= wpm_pkg::POS_W'(p)),
			.seed       ((p == 0) ? fresh_q : 1'b0),
			.close_in   (close_c[p]),
			.adv_in     (adv_c[p]),
			.close2_in  (close2_c[p]),
			.close_out  (close_c[p+1]),
			.adv_out    (adv_c[p+1]),
			.close2_out (close2_c[p+1]),
			.closed2    (closed2[p])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q   <= 1'b1;
			s1_vld_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (take) begin
				fresh_q <= text_item.last;
			end
			if (take) begin
				s1_vld_q <= 1'b1;
			end else if (adv) begin
				s1_vld_q <= 1'b0;
			end
			if (adv) begin
				res_vld_q <= s1_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_s1 <= text_item.last;
		end
		if (adv && s1_vld_q) begin
			res_q.matched   <= closed2[pat_len];
			res_q.final_res <= last_s1;
		end
	end

	assign result_valid = res_vld_q;
	assign result_item  = res_q;

endmodule

// ----- dv/tb_wildcard_pattern_matcher.sv -----
`timescale 1ns / 1ps
// testbench for the wildcard pattern matcher: queued text driver, checking monitor, apb setup
module tb_wildcard_pattern_matcher;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int STALL_CYCLES = 200;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_ready;
	wpm_pkg::text_item_t text_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	wpm_pkg::result_item_t result_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [wpm_pkg::ADDR_W-1:0] paddr = '0;
	logic [wpm_pkg::CFG_W-1:0] pwdata = '0;
	logic [wpm_pkg::CFG_W-1:0] prdata;
	logic pready;

	wpm_pkg::text_item_t text_backlog[$];
	wpm_pkg::result_item_t verdicts_due[$];
	logic [wpm_pkg::CFG_W-1:0] pat_regs[wpm_pkg::PAT_REGS];
	logic [5:0] pat_len_reg;
	logic [wpm_pkg::MAX_PATTERN:0] reach;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int error_count = 0;
	int items_queued = 0;

	wildcard_pattern_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_item(text_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic note_error(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic logic [7:0] pat_char(int p);
		if (p >= wpm_pkg::PAT_REGS * 8)
			return 8'h00;
		return pat_regs[p / 8][8 * (p % 8) +: 8];
	endfunction

	function automatic void close_stars(int n);
		for (int p = 0; p < n; p++)
			if (reach[p] && pat_char(p) == wpm_pkg::CH_STAR)
				reach[p + 1] = 1'b1;
		for (int p = n + 1; p <= wpm_pkg::MAX_PATTERN; p++)
			reach[p] = 1'b0;
	endfunction

	function automatic wpm_pkg::result_item_t match_step(wpm_pkg::text_item_t t);
		int n;
		logic [wpm_pkg::MAX_PATTERN:0] nxt;
		logic [7:0] b;
		wpm_pkg::result_item_t r;
		n = (pat_len_reg > wpm_pkg::MAX_PATTERN) ? wpm_pkg::MAX_PATTERN : int'(pat_len_reg);
		close_stars(n);
		if (t.char_valid) begin
			nxt = '0;
			for (int p = 0; p < n; p++) begin
				b = pat_char(p);
				if (reach[p]) begin
					if (b == wpm_pkg::CH_STAR)
						nxt[p] = 1'b1;
					else if (b == t.text_byte ||
						(b == wpm_pkg::CH_ANY && t.text_byte != wpm_pkg::CH_DOT))
						nxt[p + 1] = 1'b1;
				end
			end
			reach = nxt;
			close_stars(n);
		end
		r.matched = reach[n];
		r.final_res = t.last;
		if (t.last)
			reach = {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
		end else begin
			if (text_valid && text_ready)
				verdicts_due.push_back(match_step(text_item));
			if (!text_valid || text_ready) begin
				if (text_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					text_valid <= 1'b1;
					text_item <= text_backlog.pop_front();
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_mon
		wpm_pkg::result_item_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (verdicts_due.size() == 0) begin
					note_error($sformatf("unexpected result matched=%b final_res=%b",
						result_item.matched, result_item.final_res));
				end else begin
					want = verdicts_due.pop_front();
					if (result_item.matched !== want.matched)
						note_error($sformatf("matched got %b want %b",
							result_item.matched, want.matched));
					if (result_item.final_res !== want.final_res)
						note_error($sformatf("final_res got %b want %b",
							result_item.final_res, want.final_res));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= STALL_CYCLES;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [wpm_pkg::CFG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < wpm_pkg::REG_LENGTH)
			pat_regs[idx[1:0]] = val;
		else if (idx == wpm_pkg::REG_LENGTH)
			pat_len_reg = val[5:0];
	endtask

	task automatic load_pattern(logic [7:0] chars[$], logic [5:0] len_code);
		logic [wpm_pkg::CFG_W-1:0] word;
		for (int r = 0; r < wpm_pkg::PAT_REGS; r++) begin
			word = {$urandom, $urandom};
			for (int b = 0; b < 8; b++)
				if (8 * r + b < chars.size())
					word[8 * b +: 8] = chars[8 * r + b];
			cfg_write(wpm_pkg::REG_PAT0 + 3'(r), word);
		end
		word = {$urandom, $urandom};
		word[5:0] = len_code;
		cfg_write(wpm_pkg::REG_LENGTH, word);
	endtask

	function automatic logic [7:0] pick_pattern_char();
		case ($urandom_range(9))
			0, 1: return wpm_pkg::CH_STAR;
			2, 3: return wpm_pkg::CH_ANY;
			4: return wpm_pkg::CH_DOT;
			5: return 8'h00;
			6: return "a";
			7: return "b";
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] pick_text_char();
		case ($urandom_range(7))
			0, 1: return "a";
			2: return "b";
			3: return wpm_pkg::CH_DOT;
			4: return 8'h00;
			5: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic push_text(logic [7:0] b, logic cv, logic lst);
		wpm_pkg::text_item_t t;
		t.text_byte = b;
		t.char_valid = cv;
		t.last = lst;
		text_backlog.push_back(t);
		items_queued++;
	endtask

	task automatic queue_string();
		int n;
		int kind;
		logic [7:0] pc;
		logic [7:0] body[$];
		n = (pat_len_reg > wpm_pkg::MAX_PATTERN) ? wpm_pkg::MAX_PATTERN : int'(pat_len_reg);
		kind = $urandom_range(99);
		if (kind < 10) begin
			push_text(8'($urandom_range(255)), 1'b0, 1'b1);
			return;
		end
		if (kind < 75) begin
			for (int p = 0; p < n; p++) begin
				pc = pat_char(p);
				if (pc == wpm_pkg::CH_STAR)
					repeat ($urandom_range(3)) body.push_back(pick_text_char());
				else if (pc == wpm_pkg::CH_ANY || $urandom_range(24) == 0)
					body.push_back(pick_text_char());
				else
					body.push_back(pc);
			end
			if ($urandom_range(9) == 0)
				body.push_back(pick_text_char());
		end else begin
			repeat ($urandom_range(1, 8)) body.push_back(pick_text_char());
		end
		if (body.size() == 0) begin
			push_text(8'($urandom_range(255)), 1'b0, 1'b1);
			return;
		end
		foreach (body[i]) begin
			if ($urandom_range(15) == 0)
				push_text(8'($urandom_range(255)), 1'b0, 1'b0);
			push_text(body[i], 1'b1, i == body.size() - 1);
		end
	endtask

	task automatic wait_idle();
		while (text_backlog.size() != 0 || text_valid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int start;
		int n;
		logic [5:0] len_code;
		logic [7:0] chars[$];
		for (int r = 0; r < wpm_pkg::PAT_REGS; r++)
			pat_regs[r] = '0;
		pat_len_reg = '0;
		reach = {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pattern a ? * nul *
		chars = '{"a", wpm_pkg::CH_ANY, wpm_pkg::CH_STAR, 8'h00, wpm_pkg::CH_STAR};
		load_pattern(chars, 6'd5);
		push_text(8'($urandom_range(255)), 1'b0, 1'b1);
		push_text("a", 1'b1, 1'b0);
		push_text("x", 1'b1, 1'b0);
		push_text(8'($urandom_range(255)), 1'b0, 1'b0);
		push_text(8'h00, 1'b1, 1'b1);
		push_text("a", 1'b1, 1'b0);
		push_text(wpm_pkg::CH_DOT, 1'b1, 1'b0);
		push_text(8'h00, 1'b1, 1'b1);
		push_text("a", 1'b1, 1'b0);
		push_text(8'hFF, 1'b1, 1'b0);
		push_text(8'hFF, 1'b1, 1'b0);
		push_text(8'h00, 1'b1, 1'b0);
		push_text(8'hFF, 1'b1, 1'b1);
		push_text("b", 1'b1, 1'b1);
		wait_idle();

		// unmapped registers, then an empty pattern
		cfg_write(REG_SPARE_LO, {$urandom, $urandom});
		cfg_write(REG_SPARE_HI, {$urandom, $urandom});
		chars = {};
		load_pattern(chars, 6'd0);
		push_text(8'($urandom_range(255)), 1'b0, 1'b1);
		push_text("a", 1'b1, 1'b1);
		wait_idle();

		// oversized length with an all-star pattern
		chars = {};
		repeat (32) chars.push_back(wpm_pkg::CH_STAR);
		load_pattern(chars, 6'd63);
		push_text("x", 1'b1, 1'b0);
		push_text(wpm_pkg::CH_DOT, 1'b1, 1'b1);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < PHASES / 3) begin
				send_idle_pct = 33;
				recv_idle_pct = 65;
			end else if (ph < 2 * PHASES / 3) begin
				send_idle_pct = 65;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
				0: len_code = 6'd32;
				1: len_code = 6'd1;
				2: len_code = 6'($urandom_range(33, 63));
				3: len_code = 6'd0;
				default: len_code = ($urandom_range(3) == 0) ?
					6'($urandom_range(21, 32)) : 6'($urandom_range(2, 12));
			endcase
			n = (len_code > wpm_pkg::MAX_PATTERN) ? wpm_pkg::MAX_PATTERN : int'(len_code);
			chars = {};
			repeat (n) chars.push_back(pick_pattern_char());
			load_pattern(chars, len_code);
			start = items_queued;
			while (items_queued - start < PHASE_ITEMS)
				queue_string();
			// leave a string open across the next pattern change
			if ($urandom_range(2) == 0)
				repeat ($urandom_range(1, 3)) push_text(pick_text_char(), 1'b1, 1'b0);
			if (ph == 1)
				hold_req = 1'b1;
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
